### rtl/core/ocu_pkg.sv
// ----------------------------------------------------------------------------
// ocu_pkg
// Types and constants shared by the occupancy cell evidence update block.
// ----------------------------------------------------------------------------
package ocu_pkg;

    localparam int IDX_W  = 12;
    localparam int SUM_W  = 32;
    localparam int PROB_W = 17;
    localparam int NUM_W  = 51;   // dividend width of the shared divider
    localparam int DEN_W  = 35;   // divisor and remainder width
    localparam int Q_W    = 17;   // quotient bits, one per step
    localparam int DIV_CNT_W = $clog2(Q_W + 1);
    localparam int PROD_W = 50;   // 33 x 17 product

    localparam logic [PROB_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [PROB_W-1:0] HALF_Q16 = 17'd32768;

    localparam logic [16:0] FREE_THR_RST = 17'd19661;
    localparam logic [16:0] OCC_THR_RST  = 17'd45875;
    localparam logic [31:0] VAR_THR_RST  = 32'd65536000;
    localparam logic [31:0] PRIOR_O_RST  = 32'd32768;
    localparam logic [31:0] PRIOR_F_RST  = 32'd32768;
    localparam logic [31:0] MIN_W_RST    = 32'd6554;

    typedef enum logic [2:0] {
        CFG_FREE_THR  = 3'd0,
        CFG_OCC_THR   = 3'd1,
        CFG_VAR_THR   = 3'd2,
        CFG_PRIOR_OCC = 3'd3,
        CFG_PRIOR_FREE = 3'd4,
        CFG_MIN_WEIGHT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CLS_UNKNOWN   = 2'd0,
        CLS_FREE      = 2'd1,
        CLS_OCCUPIED  = 2'd2,
        CLS_UNCERTAIN = 2'd3
    } cell_class_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MOD  = 9'b000000010,
        ST_READ = 9'b000000100,
        ST_CALC = 9'b000001000,
        ST_WGT  = 9'b000010000,
        ST_PDIV = 9'b000100000,
        ST_MUL  = 9'b001000000,
        ST_VDIV = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    typedef struct packed {
        logic             flag;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] a;
    } cell_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

### rtl/core/ocu_div.sv
// ----------------------------------------------------------------------------
// ocu_div
// Restoring divider, one quotient bit per cycle. The upper dividend bits above
// Q_W must be below the divisor.
// ----------------------------------------------------------------------------
module ocu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ocu_pkg::div_req_t  req,
    output ocu_pkg::div_rsp_t  rsp
);
    import ocu_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [DEN_W-1:0]     den_reg;
    logic [Q_W-1:0]       lo_reg;
    logic [Q_W-1:0]       q_reg;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        trial    = {rem_reg, lo_reg[Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= DIV_CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DEN_W'(req.num[NUM_W-1:Q_W]);
            lo_reg  <= req.num[Q_W-1:0];
            den_reg <= req.den;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign rsp.busy = cnt_reg != '0;
    assign rsp.quo  = q_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/core/occupancy_cell_evidence_update_top.sv
// ----------------------------------------------------------------------------
// occupancy_cell_evidence_update_top
// Cell table of evidence sums with probability, variance and class per item.
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while the block is idle. With a
// power-of-two CELL_COUNT (or one of 4096 or more) an item goes from acceptance
// to a valid result through one table read, one sum update, a weight step, the
// shared divider for the probability (17 quotient steps and one to take the
// result), the shared multiplier for the squares and weighted sum, the divider
// again for the variance and an output step; a zero total weight goes from the
// weight step straight to the output. Other CELL_COUNT values first use the
// divider to reduce the cell index. The result sits in an output register,
// so the next item is taken while it waits.
module occupancy_cell_evidence_update_top #(
    parameter int CELL_COUNT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // cell_index[11:0], weight_a[43:12], weight_b[75:44]
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // cell_out, probability, variance, cell_class,
                                   // was_classified
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ocu_pkg::*;

    localparam int  ADDR_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int  XIDX_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam bit  IS_POW2 = (CELL_COUNT & (CELL_COUNT - 1)) == 0;
    localparam bit  DIRECT  = IS_POW2 || (CELL_COUNT >= (1 << IDX_W));
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(CELL_COUNT - 1);

    // configuration
    logic [16:0] free_thr_reg, occ_thr_reg;
    logic [31:0] var_thr_reg, prior_o_reg, prior_f_reg, min_w_reg;

    // item state
    state_t             state_reg, state_next;
    logic               func_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   wa_reg, wb_reg;
    logic [ADDR_W-1:0]  addr_reg;
    cell_t              rd_reg;
    cell_t              wr_cell;
    logic [SUM_W-1:0]   a_reg, b_reg;
    logic               flag_reg;
    logic [SUM_W:0]     w_reg;
    logic [SUM_W-1:0]   r_reg;
    logic [PROB_W-1:0]  prob_reg, var_reg;
    logic [PROB_W-1:0]  sa_reg, sr_reg, sb_reg;
    logic [PROD_W-1:0]  prod_reg, acc_reg;
    logic [2:0]         mk_reg;
    logic [55:0]        out_reg;
    logic               m_tvalid_reg;

    cell_t mem [CELL_COUNT];

    div_req_t div_req;
    div_rsp_t div_rsp;

    ocu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic               accept;
    logic [XIDX_W-1:0]  idx_ext;
    logic [ADDR_W-1:0]  addr_direct;
    logic [SUM_W:0]     add_a, add_b, sub_b;
    logic [SUM_W-1:0]   new_a, new_b;
    logic [SUM_W:0]     sum_ab, w_c;
    logic [SUM_W-1:0]   r_c;
    logic [DEN_W-1:0]   pnum, pden;
    logic [32:0]        mul_x;
    logic [16:0]        mul_y;
    logic [PROB_W-1:0]  d_one, d_half, sq;
    logic               out_load;
    cell_class_t        cls;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign idx_ext  = XIDX_W'(s_tdata[11:0]);
    assign addr_direct = IS_POW2 ? (idx_ext[ADDR_W-1:0] & ADDR_MASK) : idx_ext[ADDR_W-1:0];

    // new sums from the stored cell, or from the priors on a load
    always_comb
    begin
        if (!func_reg)
        begin
            add_a = {1'b0, prior_o_reg} + {1'b0, wa_reg};
            add_b = {1'b0, prior_f_reg} + {1'b0, wb_reg};
            sub_b = add_b;
        end
        else
        begin
            add_a = {1'b0, rd_reg.a} + {1'b0, wa_reg};
            add_b = {1'b0, rd_reg.b} + {1'b0, wb_reg};
            sub_b = (add_b > {1'b0, wa_reg}) ? add_b - {1'b0, wa_reg} : '0;
        end
        new_a = add_a[SUM_W] ? '1 : add_a[SUM_W-1:0];
        new_b = sub_b[SUM_W] ? '1 : sub_b[SUM_W-1:0];
        wr_cell = '{flag: func_reg, b: new_b, a: new_a};
    end

    // total weight and probability operands
    always_comb
    begin
        sum_ab = {1'b0, a_reg} + {1'b0, b_reg};
        w_c    = (sum_ab < {1'b0, min_w_reg}) ? {1'b0, min_w_reg} : sum_ab;
        r_c    = SUM_W'(w_c - sum_ab);
        if (a_reg > b_reg)
        begin
            pnum = DEN_W'({a_reg, 1'b0}) + DEN_W'(r_c);
            pden = DEN_W'({a_reg, 1'b0}) + DEN_W'({r_c, 1'b0});
        end
        else
        begin
            pnum = DEN_W'(r_c);
            pden = DEN_W'({b_reg, 1'b0}) + DEN_W'({r_c, 1'b0});
        end
    end

    // shared multiplier operands
    always_comb
    begin
        d_one  = ONE_Q16 - prob_reg;
        d_half = (prob_reg > HALF_Q16) ? prob_reg - HALF_Q16 : HALF_Q16 - prob_reg;
        sq     = prod_reg[32:16];
        unique case (mk_reg)
            3'd0:    begin mul_x = 33'(d_one);    mul_y = d_one;    end
            3'd1:    begin mul_x = 33'(d_half);   mul_y = d_half;   end
            3'd2:    begin mul_x = 33'(prob_reg); mul_y = prob_reg; end
            3'd3:    begin mul_x = 33'(a_reg);    mul_y = sa_reg;   end
            3'd4:    begin mul_x = 33'(r_reg);    mul_y = sr_reg;   end
            3'd5:    begin mul_x = 33'(b_reg);    mul_y = sb_reg;   end
            default: begin mul_x = '0;            mul_y = '0;       end
        endcase
    end

    always_comb
    begin
        if (var_reg > PROB_W'(0) && 32'(var_reg) > var_thr_reg)
            cls = CLS_UNCERTAIN;
        else if (prob_reg > occ_thr_reg)
            cls = CLS_OCCUPIED;
        else if (prob_reg < free_thr_reg)
            cls = CLS_FREE;
        else
            cls = CLS_UNKNOWN;
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.num   = NUM_W'(s_tdata[11:0]);
        div_req.den   = DEN_W'(CELL_COUNT);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (DIRECT)
                        state_next = ST_READ;
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_MOD;
                    end
                end
            end
            ST_MOD:  if (!div_rsp.busy) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_WGT;
            ST_WGT:
            begin
                if (w_c == '0)
                    state_next = ST_DONE;
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {pnum, 16'b0};
                    div_req.den   = pden;
                    state_next    = ST_PDIV;
                end
            end
            ST_PDIV: if (!div_rsp.busy) state_next = ST_MUL;
            ST_MUL:
            begin
                // wait until the last product has landed in the sum
                if (mk_reg == 3'd7)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(acc_reg);
                    div_req.den   = DEN_W'(w_reg);
                    state_next    = ST_VDIV;
                end
            end
            ST_VDIV: if (!div_rsp.busy) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            free_thr_reg <= FREE_THR_RST;
            occ_thr_reg  <= OCC_THR_RST;
            var_thr_reg  <= VAR_THR_RST;
            prior_o_reg  <= PRIOR_O_RST;
            prior_f_reg  <= PRIOR_F_RST;
            min_w_reg    <= MIN_W_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FREE_THR:   free_thr_reg <= cfg_data[16:0];
                    CFG_OCC_THR:    occ_thr_reg  <= cfg_data[16:0];
                    CFG_VAR_THR:    var_thr_reg  <= cfg_data;
                    CFG_PRIOR_OCC:  prior_o_reg  <= cfg_data;
                    CFG_PRIOR_FREE: prior_f_reg  <= cfg_data;
                    CFG_MIN_WEIGHT: min_w_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // cell table
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
            mem[addr_reg] <= wr_cell;
        rd_reg <= mem[addr_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser[0];
            idx_reg  <= s_tdata[11:0];
            wa_reg   <= s_tdata[43:12];
            wb_reg   <= s_tdata[75:44];
            addr_reg <= addr_direct;
        end
        if (state_reg == ST_MOD && !div_rsp.busy)
            addr_reg <= div_rsp.rem[ADDR_W-1:0];
        if (state_reg == ST_CALC)
        begin
            a_reg    <= new_a;
            b_reg    <= new_b;
            flag_reg <= func_reg;
        end
        if (state_reg == ST_WGT)
        begin
            w_reg    <= w_c;
            r_reg    <= r_c;
            prob_reg <= HALF_Q16;
            var_reg  <= '0;
        end
        if (state_reg == ST_PDIV && !div_rsp.busy)
        begin
            prob_reg <= (div_rsp.quo > ONE_Q16) ? ONE_Q16 : div_rsp.quo;
            mk_reg   <= '0;
            acc_reg  <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            // issue one product, retire the one before
            prod_reg <= PROD_W'(mul_x * mul_y);
            mk_reg   <= mk_reg + 1'b1;
            unique case (mk_reg)
                3'd1:    sa_reg  <= sq;
                3'd2:    sr_reg  <= sq;
                3'd3:    sb_reg  <= sq;
                3'd4, 3'd5, 3'd6: acc_reg <= acc_reg + prod_reg;
                default: ;
            endcase
        end
        if (state_reg == ST_VDIV && !div_rsp.busy)
            var_reg <= (div_rsp.quo > ONE_Q16) ? ONE_Q16 : div_rsp.quo;
        if (out_load)
            out_reg <= {7'b0, flag_reg, cls, var_reg, prob_reg, idx_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[28:12] <= ONE_Q16)
        else $error("probability above one");

    a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[45:29] <= ONE_Q16)
        else $error("variance above one");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while busy");

endmodule

### tb/tb_occupancy_cell_evidence_update_top.sv
// ----------------------------------------------------------------------------
// tb_occupancy_cell_evidence_update_top
// Self-checking bench for the occupancy cell evidence update block. Items of
// load and update are streamed in with random gaps, every result is checked
// field by field against a bench-side copy of the cell table, and the
// configuration registers are rewritten between phases while the block is
// idle, extremes included.
// ----------------------------------------------------------------------------
module tb_occupancy_cell_evidence_update_top;
    import ocu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;
    localparam int   TABLE_SIZE  = 4096;
    localparam int   SETTLE_CYCLES = 60;
    localparam logic [63:0] SAT_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic        func;
        logic [11:0] idx;
        logic [31:0] wa;
        logic [31:0] wb;
    } cell_item_t;

    typedef struct {
        logic [11:0] cell_id;
        logic [16:0] prob;
        logic [16:0] var_q;
        cell_class_t cls;
        logic        flag;
    } cell_report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // cell_index[11:0], weight_a[43:12], weight_b[75:44]
    logic [0:0]  s_tuser;    // func
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // cell_out[11:0], probability[28:12], variance[45:29],
                             // cell_class[47:46], was_classified[48]
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    occupancy_cell_evidence_update_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // bench copy of configuration and cell table
    logic [16:0] free_thr;
    logic [16:0] occ_thr;
    logic [31:0] var_thr;
    logic [31:0] prior_occ;
    logic [31:0] prior_free;
    logic [31:0] min_weight;
    logic [31:0] occ_evidence [TABLE_SIZE];
    logic [31:0] free_evidence[TABLE_SIZE];
    logic        updated      [TABLE_SIZE];

    cell_item_t   pending_items[$];
    cell_report_t expected_reports[$];
    bit           loaded_cells[TABLE_SIZE];   // used by the generator only
    int           loaded_list[$];

    int  mismatches;
    int  items_sent;
    int  reports_seen;
    bit  no_idle;
    bit  long_stall_req;
    bit  long_stall_done;
    int  long_stall_cnt;
    int  tx_gap;
    int  rx_stall;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > SAT_MAX) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic cell_report_t evidence_update(cell_item_t it);
        cell_report_t rep;
        logic [63:0] a, b, w, r, p, v, nb, dr, sa, sr, sb;
        int slot;
        slot = it.idx % TABLE_SIZE;
        if (it.func == FUNC_LOAD)
        begin
            occ_evidence[slot]  = sat32(64'(prior_occ) + it.wa);
            free_evidence[slot] = sat32(64'(prior_free) + it.wb);
            updated[slot] = 1'b0;
        end
        else
        begin
            nb = 64'(free_evidence[slot]) + it.wb;
            occ_evidence[slot] = sat32(64'(occ_evidence[slot]) + it.wa);
            nb = (nb > it.wa) ? nb - it.wa : 64'd0;
            free_evidence[slot] = sat32(nb);
            updated[slot] = 1'b1;
        end
        a = occ_evidence[slot];
        b = free_evidence[slot];
        w = a + b;
        if (w < min_weight)
            w = min_weight;
        if (w == 0)
        begin
            p = 64'd32768;
            v = 64'd0;
        end
        else
        begin
            r = w - a - b;
            if (a > b)
                p = ((2 * a + r) << 16) / (2 * (w - b));
            else
                p = (r << 16) / (2 * (w - a));
            if (p > 65536)
                p = 65536;
            dr = (p > 32768) ? p - 32768 : 32768 - p;
            sa = ((65536 - p) * (65536 - p)) >> 16;
            sr = (dr * dr) >> 16;
            sb = (p * p) >> 16;
            v = (a * sa + r * sr + b * sb) / w;
            if (v > 65536)
                v = 65536;
        end
        rep.cell_id = it.idx;
        rep.prob    = p[16:0];
        rep.var_q   = v[16:0];
        if (v > var_thr)
            rep.cls = CLS_UNCERTAIN;
        else if (p > occ_thr)
            rep.cls = CLS_OCCUPIED;
        else if (p < free_thr)
            rep.cls = CLS_FREE;
        else
            rep.cls = CLS_UNKNOWN;
        rep.flag = updated[slot];
        return rep;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // sender: one transaction in flight, gap drawn after each acceptance
    always @(posedge clk or negedge rst_n)
    begin
        cell_item_t it;
        bit offering;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   = 0;
        end
        else
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                it.func = s_tuser[0];
                it.idx  = s_tdata[11:0];
                it.wa   = s_tdata[43:12];
                it.wb   = s_tdata[75:44];
                expected_reports.push_back(evidence_update(it));
                items_sent++;
                offering = 1'b0;
                tx_gap = draw_wait();
            end
            if (!offering)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    s_tdata  <= {4'b0, it.wb, it.wa, it.idx};
                    s_tuser  <= it.func;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each transaction, then draw the next stall
    always @(posedge clk or negedge rst_n)
    begin
        cell_report_t want;
        logic [11:0] got_id;
        logic [16:0] got_p, got_v;
        logic [1:0]  got_c;
        logic        got_f;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
            long_stall_cnt = 0;
            long_stall_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                reports_seen++;
                rx_stall = draw_wait();
                got_id = m_tdata[11:0];
                got_p  = m_tdata[28:12];
                got_v  = m_tdata[45:29];
                got_c  = m_tdata[47:46];
                got_f  = m_tdata[48];
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: cell %0d", got_id);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got_id !== want.cell_id || got_p !== want.prob ||
                        got_v !== want.var_q || got_c !== want.cls || got_f !== want.flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp cell %0d p %0d v %0d cls %0d flag %0d",
                                      " / got cell %0d p %0d v %0d cls %0d flag %0d"},
                                     want.cell_id, want.prob, want.var_q, want.cls,
                                     want.flag, got_id, got_p, got_v, got_c, got_f);
                    end
                end
            end
            if (long_stall_req && !long_stall_done)
            begin
                // hold off long enough for the block to back up its input
                long_stall_cnt++;
                if (long_stall_cnt >= 300)
                    long_stall_done = 1'b1;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic add_item(logic func, logic [11:0] idx, logic [31:0] wa, logic [31:0] wb);
        cell_item_t it;
        it.func = func;
        it.idx  = idx;
        it.wa   = wa;
        it.wb   = wb;
        if (func == FUNC_LOAD && !loaded_cells[idx])
        begin
            loaded_cells[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h0010_0000);
            3: return $urandom_range(0, 32'h0000_4000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(int n);
        logic [11:0] idx;
        for (int k = 0; k < n; k++)
        begin
            if (loaded_list.size() == 0 || $urandom_range(0, 9) < 3)
            begin
                // mostly revisit a small pool so updates land on loaded cells
                idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
                add_item(FUNC_LOAD, idx, rand_weight(), rand_weight());
            end
            else
            begin
                idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                add_item(FUNC_UPDATE, idx, rand_weight(), rand_weight());
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // drive one write; the caller drops the enable after the last one
    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_FREE_THR:   free_thr   = value[16:0];
            CFG_OCC_THR:    occ_thr    = value[16:0];
            CFG_VAR_THR:    var_thr    = value;
            CFG_PRIOR_OCC:  prior_occ  = value;
            CFG_PRIOR_FREE: prior_free = value;
            CFG_MIN_WEIGHT: min_weight = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] fthr, logic [31:0] othr, logic [31:0] vthr,
                             logic [31:0] po, logic [31:0] pf, logic [31:0] mw);
        write_reg(CFG_FREE_THR, fthr);
        write_reg(CFG_OCC_THR, othr);
        write_reg(CFG_VAR_THR, vthr);
        write_reg(CFG_PRIOR_OCC, po);
        write_reg(CFG_PRIOR_FREE, pf);
        write_reg(CFG_MIN_WEIGHT, mw);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FREE_THR;
        cfg_data = '0;
        mismatches = 0;
        items_sent = 0;
        reports_seen = 0;
        no_idle = 1'b0;
        long_stall_req = 1'b0;
        free_thr = FREE_THR_RST;
        occ_thr = OCC_THR_RST;
        var_thr = VAR_THR_RST;
        prior_occ = PRIOR_O_RST;
        prior_free = PRIOR_F_RST;
        min_weight = MIN_W_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, saturation, negative free evidence, index extremes
        add_item(FUNC_LOAD, 12'd0, 32'd0, 32'd0);
        add_item(FUNC_LOAD, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(FUNC_UPDATE, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(FUNC_UPDATE, 12'd4095, 32'hFFFF_FFFF, 32'd0);
        add_item(FUNC_UPDATE, 12'd0, 32'h0001_0000, 32'h0000_8000);
        add_item(FUNC_LOAD, 12'd2730, 32'h0050_0000, 32'd0);
        add_item(FUNC_UPDATE, 12'd2730, 32'h0002_0000, 32'h0003_0000);
        add_item(FUNC_LOAD, 12'd1365, 32'd0, 32'h0050_0000);
        add_item(FUNC_UPDATE, 12'd1365, 32'd0, 32'h0010_0000);
        add_item(FUNC_UPDATE, 12'd1365, 32'h5555_5555, 32'hAAAA_AAAA);
        add_item(FUNC_LOAD, 12'd7, 32'hAAAA_AAAA, 32'h5555_5555);
        add_item(FUNC_UPDATE, 12'd7, 32'd0, 32'd0);
        wait_idle();

        // extremes of thresholds, heavy minimum weight
        write_all(32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        add_item(FUNC_LOAD, 12'd8, 32'd0, 32'd0);
        add_item(FUNC_UPDATE, 12'd8, 32'h0001_0000, 32'h0004_0000);
        add_random(100);
        wait_idle();

        write_all(32'd65536, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        add_random(100);
        wait_idle();

        // zero total weight
        write_all(32'd30000, 32'd40000, 32'd2000, 32'd0, 32'd0, 32'd0);
        add_item(FUNC_LOAD, 12'd9, 32'd0, 32'd0);
        add_item(FUNC_UPDATE, 12'd9, 32'd0, 32'd0);
        add_item(FUNC_UPDATE, 12'd9, 32'd5, 32'd3);
        no_idle = 1'b1;
        add_random(100);
        wait_idle();
        no_idle = 1'b0;

        write_all($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom,
                  $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000),
                  $urandom_range(1, 32'h0001_0000));
        add_random(130);
        wait_idle();

        // back to reset values while the receiver stalls for a long stretch
        write_all(FREE_THR_RST, OCC_THR_RST, VAR_THR_RST, PRIOR_O_RST, PRIOR_F_RST,
                  MIN_W_RST);
        add_random(150);
        long_stall_req = 1'b1;
        wait_idle();

        $display("covered %0d items, %0d results checked over six register settings",
                 items_sent, reports_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
